// ===== sv/tlsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsm_pkg
// Shared constants and types for the two-list sorted merge block.
// ----------------------------------------------------------------------------
package tlsm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W      = $clog2(2 * LIST_DEPTH + 1);
  localparam int WORD_W     = 32;

  typedef logic [1:0]               op_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [SUM_W-1:0]         sum_t;

  localparam op_t OP_LOAD_A = 2'd0;
  localparam op_t OP_LOAD_B = 2'd1;
  localparam op_t OP_START  = 2'd2;

endpackage

// ===== sv/tlsm_list_ram.sv =====
// ----------------------------------------------------------------------------
// tlsm_list_ram
// One list store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tlsm_list_ram (
  input  logic          clk,
  input  logic          we,
  input  tlsm_pkg::addr_t waddr,
  input  tlsm_pkg::word_t wdata,
  input  tlsm_pkg::addr_t raddr,
  output tlsm_pkg::word_t rdata
);
  import tlsm_pkg::*;

  word_t mem [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/two_list_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// two_list_sorted_merge
// Appends values to two sorted lists, then streams their stable merge.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                       Handshake
//  -------  ------------------------------------------  ----------------------
//  input    in_operation, in_item_value                 start && !busy
//  result   out_merged_value, out_final_flag            out_valid, one cycle
//
//  A load can be accepted every cycle while the block is not busy.
//  A start with N = count_a + count_b > 0 holds busy while the N words are
//  merged and gives one word per cycle, each from a registered output. The
//  two list RAMs are read at the next head index each cycle, so the
//  compare-and-advance loop runs at one word per cycle.
//  Synchronous active-low reset empties both lists; RAM contents are kept.
//  The receiver cannot stall.
// ----------------------------------------------------------------------------
module two_list_sorted_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  tlsm_pkg::op_t   in_operation,
  input  tlsm_pkg::word_t in_item_value,
  output logic            out_valid,
  output tlsm_pkg::word_t out_merged_value,
  output logic            out_final_flag
);
  import tlsm_pkg::*;

  typedef enum logic {ST_IDLE, ST_MERGE} state_t;

  state_t state_r, state_nxt;
  cnt_t   cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  cnt_t   ia_r, ia_nxt, ib_r, ib_nxt;
  logic   out_valid_nxt, out_final_nxt;
  word_t  out_value_nxt;

  logic   accept, we_a, we_b;
  logic   have_a, have_b, take_a, last;
  word_t  rd_a, rd_b;

  assign busy   = (state_r == ST_MERGE);
  assign accept = start && !busy;
  assign we_a   = accept && (in_operation == OP_LOAD_A) && (cnt_a_r < CNT_W'(LIST_DEPTH));
  assign we_b   = accept && (in_operation == OP_LOAD_B) && (cnt_b_r < CNT_W'(LIST_DEPTH));

  tlsm_list_ram u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[ADDR_W-1:0]),
    .wdata (in_item_value),
    .raddr (ia_nxt[ADDR_W-1:0]),
    .rdata (rd_a)
  );

  tlsm_list_ram u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[ADDR_W-1:0]),
    .wdata (in_item_value),
    .raddr (ib_nxt[ADDR_W-1:0]),
    .rdata (rd_b)
  );

  assign have_a = (ia_r < cnt_a_r);
  assign have_b = (ib_r < cnt_b_r);
  // tie goes to list A
  assign take_a = (have_a && have_b) ? (rd_a <= rd_b) : have_a;
  assign last   = (SUM_W'(ia_r) + SUM_W'(ib_r) + SUM_W'(1))
                  == (SUM_W'(cnt_a_r) + SUM_W'(cnt_b_r));

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    out_valid_nxt = 1'b0;
    out_final_nxt = 1'b0;
    out_value_nxt = take_a ? rd_a : rd_b;
    unique case (state_r)
      ST_IDLE: begin
        if (we_a) begin
          cnt_a_nxt = cnt_a_r + CNT_W'(1);
        end
        if (we_b) begin
          cnt_b_nxt = cnt_b_r + CNT_W'(1);
        end
        // heads of both lists are read at index 0 while idle
        if (accept && (in_operation == OP_START) && ((cnt_a_r | cnt_b_r) != '0)) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        out_valid_nxt = 1'b1;
        out_final_nxt = last;
        if (take_a) begin
          ia_nxt = ia_r + CNT_W'(1);
        end else begin
          ib_nxt = ib_r + CNT_W'(1);
        end
        if (last) begin
          state_nxt = ST_IDLE;
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          ia_nxt    = '0;
          ib_nxt    = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      ia_r      <= '0;
      ib_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_a_r   <= cnt_a_nxt;
      cnt_b_r   <= cnt_b_nxt;
      ia_r      <= ia_nxt;
      ib_r      <= ib_nxt;
      out_valid <= out_valid_nxt;
    end
    out_merged_value <= out_value_nxt;
    out_final_flag   <= out_final_nxt && rst_n;
  end

  // ---- checks --------------------------------------------------------------
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (ia_r <= cnt_a_r) && (ib_r <= cnt_b_r)
                              && (have_a || have_b))
    else $error("merge index past list end");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_flag |-> out_valid && (cnt_a_r == '0) && (cnt_b_r == '0))
    else $error("final word without cleared counts");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_MERGE))
    else $error("result word outside a merge");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (ia_r == '0) && (ib_r == '0))
    else $error("head indexes not rewound");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for two_list_sorted_merge
// Loads sorted (and sometimes unsorted) lists A and B with random values,
// starts merges and checks every merged word and its last flag against an
// in-bench merge predictor. Covers full-list drops, empty merges, ties and
// the unused opcode, with random idle gaps on the input side.
// ----------------------------------------------------------------------------
module testbench;
  import tlsm_pkg::*;

  localparam op_t OP_UNUSED   = 2'd3;
  localparam int  ITEM_TARGET = 260;
  localparam int  IDLE_LIMIT  = 2000;
  localparam int  DRAIN_WAIT  = 2 * LIST_DEPTH + 8;

  typedef struct {
    word_t value;
    logic  last;
  } merged_word_t;

  class merge_predictor;
    word_t          list_a[LIST_DEPTH];
    word_t          list_b[LIST_DEPTH];
    cnt_t           len_a;
    cnt_t           len_b;
    merged_word_t   expected_words[$];
    int             errors;
    int             merges;
    int             checked;
    int             dropped;
    int             ignored;

    function void note_word(op_t op, word_t value);
      int unsigned  ia;
      int unsigned  ib;
      int unsigned  total;
      bit           take_a;
      merged_word_t w;
      ia = 0;
      ib = 0;
      case (op)
        OP_LOAD_A: begin
          if (len_a < LIST_DEPTH) begin
            list_a[len_a] = value;
            len_a++;
          end else dropped++;
        end
        OP_LOAD_B: begin
          if (len_b < LIST_DEPTH) begin
            list_b[len_b] = value;
            len_b++;
          end else dropped++;
        end
        OP_START: begin
          total = len_a + len_b;
          if (total > 0) merges++;
          for (int k = 0; k < total; k++) begin
            // A wins ties, keeps the merge stable
            if (ia < len_a && ib < len_b) take_a = (list_a[ia] <= list_b[ib]);
            else take_a = (ia < len_a);
            if (take_a) begin
              w.value = list_a[ia];
              ia++;
            end else begin
              w.value = list_b[ib];
              ib++;
            end
            w.last = (k + 1 == total);
            expected_words.push_back(w);
          end
          len_a = '0;
          len_b = '0;
        end
        default: ignored++;
      endcase
    endfunction

    function void check_word(word_t value, logic last);
      merged_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected merged word: value %0d, last %0b", value, last);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      checked++;
      if (value !== w.value) begin
        $error("merged_value: expected %0d, got %0d", w.value, value);
        errors++;
      end
      if (last !== w.last) begin
        $error("final_flag: expected %0b, got %0b", w.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic  clk           = 1'b0;
  logic  rst_n         = 1'b0;
  logic  start         = 1'b0;
  op_t   in_operation  = OP_LOAD_A;
  word_t in_item_value = '0;
  logic  busy;
  logic  out_valid;
  word_t out_merged_value;
  logic  out_final_flag;

  merge_predictor sb = new;
  int words_sent = 0;
  int idle_cycles = 0;

  two_list_sorted_merge dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_final_flag   (out_final_flag)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // monitor: sample pre-edge values of both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_word(in_operation, in_item_value);
      if (out_valid) sb.check_word(out_merged_value, out_final_flag);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // call right after a rising edge; returns at the accepting edge (plus gap)
  task automatic send_word(input op_t op, input word_t value, input bit no_idle);
    int r;
    int gap;
    in_operation  <= op;
    in_item_value <= value;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    if (op != OP_UNUSED) words_sent++;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_batch(input int batch_no);
    word_t vals_a[$];
    word_t vals_b[$];
    word_t v;
    int    na;
    int    nb;
    int    r;
    bit    ties;
    bit    no_idle;
    if (batch_no == 0) begin
      na = LIST_DEPTH + 2;
      nb = LIST_DEPTH + 1;
    end else begin
      r  = $urandom_range(0, 99);
      na = (r < 6) ? $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 2) : $urandom_range(0, 8);
      r  = $urandom_range(0, 99);
      nb = (r < 6) ? $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 2) : $urandom_range(0, 8);
    end
    ties    = ($urandom_range(0, 2) == 0);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < na + nb; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) v = 32'sh8000_0000;
      else if (r < 8) v = 32'sh7fff_ffff;
      else if (ties) v = word_t'(int'($urandom_range(0, 15)) - 8);
      else v = word_t'($urandom);
      if (k < na) vals_a.push_back(v);
      else vals_b.push_back(v);
    end
    // most batches are well-formed sorted lists
    if ($urandom_range(0, 9) != 0) begin
      vals_a.sort();
      vals_b.sort();
    end
    while (vals_a.size() > 0 || vals_b.size() > 0) begin
      if ($urandom_range(0, 19) == 0) send_word(OP_UNUSED, word_t'($urandom), no_idle);
      if (vals_b.size() == 0 || (vals_a.size() > 0 && $urandom_range(0, 1) == 0))
        send_word(OP_LOAD_A, vals_a.pop_front(), no_idle);
      else
        send_word(OP_LOAD_B, vals_b.pop_front(), no_idle);
    end
    // occasionally let the next batch append to these lists
    if ($urandom_range(0, 19) != 0) send_word(OP_START, word_t'($urandom), no_idle);
  endtask

  initial begin
    int batch_no;
    batch_no = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty merge, unused opcode, extremes and ties, single-list merges
    send_word(OP_START, 32'sh0000_0000, 1'b0);
    send_word(OP_UNUSED, 32'shffff_ffff, 1'b0);
    send_word(OP_LOAD_A, 32'sh8000_0000, 1'b0);
    send_word(OP_LOAD_B, 32'sh8000_0000, 1'b0);
    send_word(OP_LOAD_A, -32'sd1, 1'b0);
    send_word(OP_LOAD_B, 32'sd0, 1'b0);
    send_word(OP_LOAD_A, 32'sd0, 1'b0);
    send_word(OP_LOAD_B, 32'sd5, 1'b0);
    send_word(OP_LOAD_A, 32'sd5, 1'b0);
    send_word(OP_LOAD_B, 32'sh7fff_ffff, 1'b0);
    send_word(OP_START, 32'shffff_ffff, 1'b1);
    send_word(OP_LOAD_A, 32'sh7fff_ffff, 1'b1);
    send_word(OP_START, 32'sh5555_5555, 1'b0);
    send_word(OP_LOAD_B, -32'sd7, 1'b0);
    send_word(OP_LOAD_B, 32'sd3, 1'b0);
    send_word(OP_START, 32'shaaaa_aaaa, 1'b0);

    while (words_sent < ITEM_TARGET) begin
      run_batch(batch_no);
      batch_no++;
    end
    send_word(OP_START, '0, 1'b1);
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d merged words never arrived", sb.pending());
      sb.errors++;
    end

    $display("Run covered %0d input words, %0d non-empty merges, %0d merged words checked.",
             words_sent, sb.merges, sb.checked);
    $display("Loads dropped on full lists: %0d; unused-opcode words ignored: %0d.",
             sb.dropped, sb.ignored);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tlsm_pkg.sv
sv/tlsm_list_ram.sv
sv/two_list_sorted_merge.sv
tb/testbench.sv
